### rtl/aesb_pkg.sv
package aesb_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int NUM_RK     = NUM_ROUNDS + 1;
  localparam int RK_AW      = $clog2(NUM_RK);

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] FUNC_POLY = 8'h1b;

  typedef struct packed {
    logic        func;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [RK_AW-1:0] addr;
    logic [127:0]     data;
  } rk_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDK,
    ST_ROUND
  } seq_state_t;

  typedef logic [7:0] byte_tab_t [256];

  localparam byte_tab_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_tab_t invert_tab(input byte_tab_t t);
    byte_tab_t r;
    for (int i = 0; i < 256; i++) begin
      r[t[i]] = i[7:0];
    end
    return r;
  endfunction

  localparam byte_tab_t INV_SBOX = invert_tab(SBOX);

  function automatic logic [7:0] rcon(input logic [RK_AW-1:0] k);
    logic [7:0] r;
    case (k)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? FUNC_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] transpose(input logic [127:0] x);
    logic [127:0] y;
    for (int j = 0; j < 16; j++) begin
      y[127-8*j -: 8] = x[127-8*(((j & 3) << 2) + (j >> 2)) -: 8];
    end
    return y;
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] y;
    for (int j = 0; j < 16; j++) begin
      y[127-8*j -: 8] = inv ? INV_SBOX[s[127-8*j -: 8]] : SBOX[s[127-8*j -: 8]];
    end
    return y;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] y;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        y[127-8*(4*c+r) -: 8] = inv ? s[127-8*(4*((c - r + 4) & 3) + r) -: 8]
                                    : s[127-8*(4*((c + r) & 3) + r) -: 8];
      end
    end
    return y;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] y;
    logic [7:0]   a [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m1 [4];
    logic [7:0]   m2 [4];
    logic [7:0]   m3 [4];
    logic [7:0]   m0 [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127-8*(4*c+k) -: 8];
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
        if (inv) begin
          m0[k] = x8[k] ^ x4[k] ^ x2[k];
          m1[k] = x8[k] ^ x2[k] ^ a[k];
          m2[k] = x8[k] ^ x4[k] ^ a[k];
          m3[k] = x8[k] ^ a[k];
        end else begin
          m0[k] = x2[k];
          m1[k] = x2[k] ^ a[k];
          m2[k] = a[k];
          m3[k] = a[k];
        end
      end
      for (int r = 0; r < 4; r++) begin
        y[127-8*(4*c+r) -: 8] = m0[r] ^ m1[(r + 1) & 3] ^ m2[(r + 2) & 3] ^ m3[(r + 3) & 3];
      end
    end
    return y;
  endfunction

endpackage

### rtl/aesb_key_exp.sv
module aesb_key_exp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output aesb_pkg::rk_wr_t    rk_wr,
  output logic                busy
);

  logic [63:0]              key_high_r, key_high_nxt;
  logic [63:0]              key_low_r, key_low_nxt;
  logic                     busy_r, busy_nxt;
  logic [aesb_pkg::RK_AW-1:0] cnt_r, cnt_nxt;
  logic [127:0]             cur_r;
  logic [127:0]             rk_val;
  logic [31:0]              t_w;
  logic [31:0]              n0, n1, n2, n3;

  always_comb begin
    t_w = aesb_pkg::sub_word({cur_r[23:0], cur_r[31:24]}) ^ {aesb_pkg::rcon(cnt_r), 24'h0};
    n0  = cur_r[127:96] ^ t_w;
    n1  = cur_r[95:64] ^ n0;
    n2  = cur_r[63:32] ^ n1;
    n3  = cur_r[31:0] ^ n2;
    rk_val = (cnt_r == '0) ? {key_high_r, key_low_r} : {n0, n1, n2, n3};
  end

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    busy_nxt     = busy_r;
    cnt_nxt      = cnt_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == aesb_pkg::RK_AW'(aesb_pkg::NUM_ROUNDS)) begin
        busy_nxt = 1'b0;
      end
    end
    if (cfg_we) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      case (cfg_index)
        aesb_pkg::REG_KEY_HIGH: key_high_nxt = cfg_data;
        aesb_pkg::REG_KEY_LOW:  key_low_nxt  = cfg_data;
        default:                key_high_nxt = key_high_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      busy_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      busy_r     <= busy_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      cur_r <= rk_val;
    end
  end

  assign rk_wr.we   = busy_r;
  assign rk_wr.addr = cnt_r;
  assign rk_wr.data = rk_val;
  assign busy       = busy_r;

endmodule

### rtl/aes128_block_cipher.sv
// AES-128 engine with a transposed block layout, one round per cycle on a shared round
// unit. The first round key is fetched at the transfer edge, then an initial key addition
// step and the ten rounds follow, each paced by a registered read of the round key
// memory. The engine returns to idle as the result is registered, so the next block can
// be taken while that result is presented; no block is taken before the previous block's
// result is registered, and a stalled result holds the engine in its last round. A write
// to either key register restarts the key schedule, which fills the eleven round keys in
// turn; no block is taken until that completes. No block should be sent before the first
// key write.
module aes128_block_cipher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  aesb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aesb_pkg::out_item_t out_data
);

  aesb_pkg::rk_wr_t           rk_wr;
  logic                       exp_busy;
  logic [127:0]               rk_mem [aesb_pkg::NUM_RK];
  logic [127:0]               rk_q;
  logic [aesb_pkg::RK_AW-1:0] rd_addr;

  aesb_pkg::seq_state_t       st_r, st_nxt;
  logic [aesb_pkg::RK_AW-1:0] cnt_r, cnt_nxt;
  logic                       func_r, func_nxt;
  logic [127:0]               s_r, s_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [127:0]               res_r, res_nxt;
  logic                       in_acc;
  logic                       last;
  logic                       out_free;
  logic [127:0]               enc_v, dec_v;

  aesb_key_exp u_key_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rk_wr     (rk_wr),
    .busy      (exp_busy)
  );

  always_ff @(posedge clk) begin
    if (rk_wr.we) begin
      rk_mem[rk_wr.addr] <= rk_wr.data;
    end
    rk_q <= rk_mem[rd_addr];
  end

  assign in_stall = exp_busy || (st_r != aesb_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last     = func_r ? (cnt_r == '0)
                           : (cnt_r == aesb_pkg::RK_AW'(aesb_pkg::NUM_ROUNDS));

  always_comb begin
    logic [127:0] t;
    t     = aesb_pkg::shift_rows(aesb_pkg::sub_bytes(s_r, 1'b0), 1'b0);
    enc_v = (last ? t : aesb_pkg::mix_columns(t, 1'b0)) ^ rk_q;
  end

  always_comb begin
    logic [127:0] t;
    t     = aesb_pkg::sub_bytes(aesb_pkg::shift_rows(s_r, 1'b1), 1'b1) ^ rk_q;
    dec_v = last ? t : aesb_pkg::mix_columns(t, 1'b1);
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    func_nxt      = func_r;
    s_nxt         = s_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      aesb_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_nxt   = aesb_pkg::ST_ADDK;
          func_nxt = in_data.func;
          cnt_nxt  = in_data.func ? aesb_pkg::RK_AW'(aesb_pkg::NUM_ROUNDS) : '0;
          s_nxt    = aesb_pkg::transpose({in_data.block_high, in_data.block_low});
        end
      end
      aesb_pkg::ST_ADDK: begin
        st_nxt  = aesb_pkg::ST_ROUND;
        s_nxt   = s_r ^ rk_q;
        cnt_nxt = func_r ? cnt_r - 1'b1 : cnt_r + 1'b1;
      end
      aesb_pkg::ST_ROUND: begin
        if (!last) begin
          s_nxt   = func_r ? dec_v : enc_v;
          cnt_nxt = func_r ? cnt_r - 1'b1 : cnt_r + 1'b1;
        end else if (out_free) begin
          res_nxt       = aesb_pkg::transpose(func_r ? dec_v : enc_v);
          out_valid_nxt = 1'b1;
          st_nxt        = aesb_pkg::ST_IDLE;
        end
      end
      default: st_nxt = aesb_pkg::ST_IDLE;
    endcase
    rd_addr = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= aesb_pkg::ST_IDLE;
      cnt_r       <= '0;
      func_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      func_r      <= func_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    res_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_data.result_high = res_r[127:64];
  assign out_data.result_low  = res_r[63:0];

`ifndef SYNTHESIS
  a_no_accept_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !exp_busy) else $error("block transfer during key schedule");
  a_accept_to_addk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == aesb_pkg::ST_ADDK) else $error("sequencer missed a transfer");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= aesb_pkg::RK_AW'(aesb_pkg::NUM_ROUNDS)) else $error("round counter overrun");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_r))
    else $error("pending result overwritten");
`endif

endmodule

### dv/aes128_block_cipher_checker.sv
module aes128_block_cipher_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  aesb_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  aesb_pkg::out_item_t out_data,
  output int                  errors,
  output int                  pending
);

  logic [63:0]         key_hi;
  logic [63:0]         key_lo;
  logic [127:0]        round_keys [11];
  logic [7:0]          inv_sbox [256];
  aesb_pkg::out_item_t expected_blocks [$];

  initial begin
    for (int i = 0; i < 256; i++) begin
      inv_sbox[aesb_pkg::SBOX[i]] = i[7:0];
    end
    errors  = 0;
    pending = 0;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc ^= x;
      end
      x = gf_double(x);
    end
    return acc;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc   = 8'h01;
    w[0] = key_hi[63:32];
    w[1] = key_hi[31:0];
    w[2] = key_lo[63:32];
    w[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if ((i % 4) == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aesb_pkg::SBOX[t[31:24]], aesb_pkg::SBOX[t[23:16]],
             aesb_pkg::SBOX[t[15:8]], aesb_pkg::SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = gf_double(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int n = 0; n < 11; n++) begin
      round_keys[n] = {w[4*n], w[4*n+1], w[4*n+2], w[4*n+3]};
    end
  endfunction

  // State byte b (row b%4, column b/4) sits at bits 127-8b.
  function automatic logic [127:0] byte_sub(input logic [127:0] s, input logic inv);
    logic [127:0] y;
    for (int b = 0; b < 16; b++) begin
      y[127-8*b -: 8] = inv ? inv_sbox[s[127-8*b -: 8]] : aesb_pkg::SBOX[s[127-8*b -: 8]];
    end
    return y;
  endfunction

  function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
    logic [127:0] y;
    int src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c - r + 4) % 4) : ((c + r) % 4);
        y[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
      end
    end
    return y;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
    logic [127:0] y;
    logic [7:0]   coef [4];
    logic [7:0]   v;
    if (inv) begin
      coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v ^= gf_product(s[127-8*(4*c+k) -: 8], coef[(k - r + 4) % 4]);
        end
        y[127-8*(4*c+r) -: 8] = v;
      end
    end
    return y;
  endfunction

  function automatic aesb_pkg::out_item_t cipher_block(input aesb_pkg::in_item_t it);
    logic [127:0]        blk;
    logic [127:0]        s;
    aesb_pkg::out_item_t res;
    blk = {it.block_high, it.block_low};
    for (int k = 0; k < 16; k++) begin
      s[127-8*(4*(k%4)+k/4) -: 8] = blk[127-8*k -: 8];
    end
    if (it.func) begin
      s ^= round_keys[10];
      for (int n = 9; n >= 0; n--) begin
        s = byte_sub(row_rotate(s, 1'b1), 1'b1) ^ round_keys[n];
        if (n != 0) begin
          s = column_mix(s, 1'b1);
        end
      end
    end else begin
      s ^= round_keys[0];
      for (int n = 1; n <= 10; n++) begin
        s = row_rotate(byte_sub(s, 1'b0), 1'b0);
        if (n != 10) begin
          s = column_mix(s, 1'b0);
        end
        s ^= round_keys[n];
      end
    end
    for (int k = 0; k < 16; k++) begin
      blk[127-8*k -: 8] = s[127-8*(4*(k%4)+k/4) -: 8];
    end
    res.result_high = blk[127:64];
    res.result_low  = blk[63:0];
    return res;
  endfunction

  always @(posedge clk) begin
    aesb_pkg::out_item_t want;
    if (!rst_n) begin
      key_hi = '0;
      key_lo = '0;
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == aesb_pkg::REG_KEY_HIGH) begin
          key_hi = cfg_data;
        end else begin
          key_lo = cfg_data;
        end
        expand_round_keys();
      end
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(cipher_block(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, got %h %h", $time,
                   out_data.result_high, out_data.result_low);
        end else begin
          want = expected_blocks.pop_front();
          if (out_data.result_high !== want.result_high) begin
            errors++;
            $display("%0t: result_high mismatch, expected %h, got %h", $time,
                     want.result_high, out_data.result_high);
          end
          if (out_data.result_low !== want.result_low) begin
            errors++;
            $display("%0t: result_low mismatch, expected %h, got %h", $time,
                     want.result_low, out_data.result_low);
          end
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

### dv/aes128_block_cipher_tb.sv
module aes128_block_cipher_tb;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [63:0]         cfg_data;
  logic                in_valid;
  logic                in_stall;
  aesb_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  aesb_pkg::out_item_t out_data;
  int                  errors;
  int                  pending;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  hold_len;
  int                  cycles;

  aes128_block_cipher u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  aes128_block_cipher_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver holds off for a counted stretch whenever one is requested.
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len  <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The sender stops offering and first lets the checker update, so that the count of
  // outstanding transfers includes the last block taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_block(input logic func, input logic [63:0] hi, input logic [63:0] lo);
    in_valid           <= 1'b1;
    in_data.func       <= func;
    in_data.block_high <= hi;
    in_data.block_low  <= lo;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_block($urandom_range(1), {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    cycles         = 0;
    hold_len       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = aesb_pkg::REG_KEY_HIGH;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_key(aesb_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    write_key(aesb_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);
    send_block(1'b0, {8{8'haa}}, {8{8'h55}});
    send_block(1'b1, {8{8'h55}}, {8{8'haa}});

    write_key(aesb_pkg::REG_KEY_HIGH, '0);
    write_key(aesb_pkg::REG_KEY_LOW, '0);
    send_block(1'b0, '0, '0);
    send_block(1'b1, '1, '1);
    write_key(aesb_pkg::REG_KEY_HIGH, '1);
    write_key(aesb_pkg::REG_KEY_LOW, '1);
    send_block(1'b0, '0, '1);
    send_block(1'b1, '1, '0);

    // The receiver stops for a long stretch while blocks keep coming.
    drain_results();
    hold_len = 300;
    send_random(6);
    drain_results();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      write_key(aesb_pkg::REG_KEY_HIGH, {$urandom, $urandom});
      write_key(aesb_pkg::REG_KEY_LOW, {$urandom, $urandom});
      send_random(120);
      drain_results();
      if (seg % 2 == 1) begin
        write_key(aesb_pkg::REG_KEY_LOW, {$urandom, $urandom});
      end
      send_random(120);
    end

    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/aesb_pkg.sv
rtl/aesb_key_exp.sv
rtl/aes128_block_cipher.sv
dv/aes128_block_cipher_checker.sv
dv/aes128_block_cipher_tb.sv
